@@ src/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ipc_pkg.sv @@
`timescale 1ns / 1ps
package ipc_pkg;

  localparam int unsigned ADC_FULL_SCALE = 4095;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned RAW_W    = 12;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PERIOD_W = 5;
  localparam int unsigned ONTIME_W = 3;
  localparam int unsigned THRESH_W = 6;
  localparam int unsigned MOIST_W  = 7;
  localparam int unsigned TIMER_W  = 8;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_BUTTON = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_THRESH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMED  = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN  = 5'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_INIT = 5'd15;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 5'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_STEP = 5'd5;

  localparam logic [ONTIME_W-1:0] ONTIME_MIN  = 3'd1;
  localparam logic [ONTIME_W-1:0] ONTIME_INIT = 3'd3;
  localparam logic [ONTIME_W-1:0] ONTIME_MAX  = 3'd5;
  localparam logic [ONTIME_W-1:0] ONTIME_STEP = 3'd2;

  localparam logic [THRESH_W-1:0] THRESH_MIN  = 6'd15;
  localparam logic [THRESH_W-1:0] THRESH_INIT = 6'd30;
  localparam logic [THRESH_W-1:0] THRESH_MAX  = 6'd45;
  localparam logic [THRESH_W-1:0] THRESH_STEP = 6'd15;

  localparam int unsigned MOIST_FULL = 100;
  localparam logic [TIMER_W-1:0] TIMER_MAX = 8'd255;

  // Percentage scaling uses a rounded-up reciprocal of the full scale. With
  // raw * 100 below 2^PROD_IN_W and the shift widened by the bits of the full
  // scale, the truncated product equals the exact quotient.
  localparam int unsigned PROD_IN_W = RAW_W + 7;
  localparam int unsigned DIV_SHIFT = PROD_IN_W + $clog2(ADC_FULL_SCALE);
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;
  localparam longint unsigned SCALE_MUL = DIV_RECIP * MOIST_FULL;
  localparam int unsigned SCALE_MUL_W = $clog2(SCALE_MUL + 1);
  localparam int unsigned PROD_W = RAW_W + SCALE_MUL_W;
  localparam int unsigned QUOT_W =
    (PROD_W - DIV_SHIFT > MOIST_W) ? (PROD_W - DIV_SHIFT) : MOIST_W;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             thresh_press;
    logic             ontime_press;
    logic             period_press;
    logic             mode_press;
    logic [RAW_W-1:0] raw_sample;
  } item_t;

  typedef struct packed {
    logic [MOIST_W-1:0]  cur_moisture;
    logic [THRESH_W-1:0] cur_threshold;
    logic [ONTIME_W-1:0] cur_ontime;
    logic [PERIOD_W-1:0] cur_period;
    logic [MODE_W-1:0]   cur_mode;
    logic                pump_on;
  } result_t;

  // Pipeline control between the input register and the rest of the block.
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

@@ src/ipc_in_reg.sv @@
`timescale 1ns / 1ps
module ipc_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  ipc_pkg::item_t        in_item,
  input  logic                  advance,
  output ipc_pkg::pipe_ctl_t    ctl,
  output ipc_pkg::item_t        item
);

  logic           valid_r;
  logic           valid_nxt;
  ipc_pkg::item_t item_r;

  // The stage frees up either when empty or when its item moves on.
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule

@@ src/ipc_ctrl.sv @@
`timescale 1ns / 1ps
module ipc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  ipc_pkg::pipe_ctl_t  ctl,
  input  ipc_pkg::item_t      item,
  output ipc_pkg::result_t    result
);

  logic [ipc_pkg::MODE_W-1:0]   mode_r,    mode_nxt;
  logic [ipc_pkg::PERIOD_W-1:0] period_r,  period_nxt;
  logic [ipc_pkg::ONTIME_W-1:0] ontime_r,  ontime_nxt;
  logic [ipc_pkg::THRESH_W-1:0] thresh_r,  thresh_nxt;
  logic [ipc_pkg::MOIST_W-1:0]  moist_r,   moist_nxt;
  logic [ipc_pkg::TIMER_W-1:0]  timer_r,   timer_nxt;
  logic                         water_r,   water_nxt;
  logic                         pump_r,    pump_nxt;

  logic [ipc_pkg::PROD_W-1:0]  scale_prod;
  logic [ipc_pkg::QUOT_W-1:0]  scale_quot;
  logic [ipc_pkg::MOIST_W-1:0] scaled;
  logic [ipc_pkg::TIMER_W-1:0] timer_inc;
  logic                        fire;

  assign fire = ctl.valid && ctl.advance;

  assign scale_prod = ipc_pkg::PROD_W'(item.raw_sample)
                    * ipc_pkg::PROD_W'(ipc_pkg::SCALE_MUL);
  assign scale_quot = ipc_pkg::QUOT_W'(scale_prod >> ipc_pkg::DIV_SHIFT);
  assign scaled = (scale_quot > ipc_pkg::QUOT_W'(ipc_pkg::MOIST_FULL))
                ? ipc_pkg::MOIST_W'(ipc_pkg::MOIST_FULL)
                : ipc_pkg::MOIST_W'(scale_quot);

  assign timer_inc = (timer_r < ipc_pkg::TIMER_MAX) ? (timer_r + 8'd1) : timer_r;

  always_comb begin
    mode_nxt   = mode_r;
    period_nxt = period_r;
    ontime_nxt = ontime_r;
    thresh_nxt = thresh_r;
    moist_nxt  = moist_r;
    timer_nxt  = timer_r;
    water_nxt  = water_r;
    pump_nxt   = pump_r;
    unique case (item.op)
      ipc_pkg::OP_SAMPLE: begin
        moist_nxt = scaled;
      end
      ipc_pkg::OP_BUTTON: begin
        if (item.mode_press) begin
          mode_nxt = (mode_r == ipc_pkg::MODE_THRESH) ? ipc_pkg::MODE_TIMED
                                                      : ipc_pkg::MODE_THRESH;
        end
        if (item.period_press) begin
          period_nxt = (period_r < ipc_pkg::PERIOD_MAX)
                     ? (period_r + ipc_pkg::PERIOD_STEP) : ipc_pkg::PERIOD_MIN;
        end
        if (item.ontime_press) begin
          ontime_nxt = (ontime_r < ipc_pkg::ONTIME_MAX)
                     ? (ontime_r + ipc_pkg::ONTIME_STEP) : ipc_pkg::ONTIME_MIN;
        end
        if (item.thresh_press) begin
          thresh_nxt = (thresh_r < ipc_pkg::THRESH_MAX)
                     ? (thresh_r + ipc_pkg::THRESH_STEP) : ipc_pkg::THRESH_MIN;
        end
      end
      ipc_pkg::OP_TICK: begin
        timer_nxt = timer_inc;
        if (mode_r == ipc_pkg::MODE_THRESH) begin
          pump_nxt = ({1'b0, moist_r} < {2'b00, thresh_r});
        end else if (mode_r == ipc_pkg::MODE_TIMED) begin
          // A new watering window opens once the period has elapsed; it
          // closes, and the timer restarts, when the on-time is used up.
          if (!water_r && (timer_inc >= ipc_pkg::TIMER_W'(period_r))) begin
            water_nxt = 1'b1;
            timer_nxt = '0;
          end
          if (water_nxt && (timer_nxt < ipc_pkg::TIMER_W'(ontime_r))) begin
            pump_nxt = 1'b1;
          end else begin
            pump_nxt = 1'b0;
            if (water_nxt) begin
              water_nxt = 1'b0;
              timer_nxt = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ipc_pkg::MODE_TIMED;
      period_r <= ipc_pkg::PERIOD_INIT;
      ontime_r <= ipc_pkg::ONTIME_INIT;
      thresh_r <= ipc_pkg::THRESH_INIT;
      moist_r  <= '0;
      timer_r  <= '0;
      water_r  <= 1'b0;
      pump_r   <= 1'b0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      period_r <= period_nxt;
      ontime_r <= ontime_nxt;
      thresh_r <= thresh_nxt;
      moist_r  <= moist_nxt;
      timer_r  <= timer_nxt;
      water_r  <= water_nxt;
      pump_r   <= pump_nxt;
    end
  end

  assign result.pump_on       = pump_nxt;
  assign result.cur_mode      = mode_nxt;
  assign result.cur_period    = period_nxt;
  assign result.cur_ontime    = ontime_nxt;
  assign result.cur_threshold = thresh_nxt;
  assign result.cur_moisture  = moist_nxt;

endmodule

@@ src/ipc_out_reg.sv @@
`timescale 1ns / 1ps
module ipc_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load_valid,
  input  ipc_pkg::result_t                    result,
  output logic                                advance,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ipc_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic             valid_r;
  logic             valid_nxt;
  ipc_pkg::result_t data_r;

  // The register takes a new result when empty or when its transaction completes.
  assign advance = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

@@ src/irrigation_pump_controller_core.sv @@
`timescale 1ns / 1ps
// Irrigation pump controller. Every accepted transaction (sensor sample, button
// presses or control tick, chosen by in_tuser) yields exactly one result
// transaction with the pump drive and the settings after that item. The block
// accepts one transaction per clock unless the output stalls. The input
// register takes the item at the accepting edge and the result register
// takes the updated state when it is free, with the combinational update
// logic between them; out_tvalid offers the result. in_tready drops only
// while both registers hold items and out_tready is low. Moisture is scaled as
// raw * 100 / full scale by a constant reciprocal multiply, saturated at 100.
module irrigation_pump_controller_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // raw_sample[11:0], mode_press[12], period_press[13], ontime_press[14],
  // thresh_press[15]
  input  logic [ipc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op[1:0]
  input  logic [ipc_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pump_on[0], cur_mode[2:1], cur_period[7:3], cur_ontime[10:8],
  // cur_threshold[16:11], cur_moisture[23:17]
  output logic [ipc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  ipc_pkg::item_t     in_item;
  ipc_pkg::item_t     item;
  ipc_pkg::pipe_ctl_t ctl;
  ipc_pkg::result_t   result;
  logic               advance;

  assign in_item.op           = in_tuser;
  assign in_item.raw_sample   = in_tdata[11:0];
  assign in_item.mode_press   = in_tdata[12];
  assign in_item.period_press = in_tdata[13];
  assign in_item.ontime_press = in_tdata[14];
  assign in_item.thresh_press = in_tdata[15];

  ipc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .advance   (advance),
    .ctl       (ctl),
    .item      (item)
  );

  ipc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (item),
    .result (result)
  );

  ipc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (ctl.valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ src/ipc_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ipc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ipc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  ipc_pkg::result_t res;
  logic             mode_ok;
  logic             period_ok;

  assign res       = out_tdata;
  assign mode_ok   = (res.cur_mode == ipc_pkg::MODE_THRESH)
                  || (res.cur_mode == ipc_pkg::MODE_TIMED);
  assign period_ok = (res.cur_period == ipc_pkg::PERIOD_MIN)
                  || (res.cur_period == ipc_pkg::PERIOD_INIT)
                  || (res.cur_period == ipc_pkg::PERIOD_MAX);

  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid right after reset")
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `ASSERT_CLKD(a_mode_legal, clk, rst_n, out_tvalid |-> mode_ok, "illegal mode in result")
  `ASSERT_CLKD(a_period_legal, clk, rst_n, out_tvalid |-> period_ok, "illegal period in result")
  `ASSERT_CLKD(a_ready_free, clk, rst_n, !out_tvalid |-> in_tready, "input stalled while empty")

endmodule

bind irrigation_pump_controller_core ipc_checker u_ipc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
